// ----- rtl/srpe_pkg.sv -----
// ----------------------------------------------------------------------------
// srpe_pkg
// shared constants, types and codes of the reed switch position emulator
// ----------------------------------------------------------------------------
package srpe_pkg;

	localparam int STAMP_BITS  = 48;
	localparam int PERIOD_BITS = 32;
	localparam int REG_W       = 32;

	// usable period width: the register holds 32 bits at most
	localparam int PER_W = (PERIOD_BITS < REG_W) ? PERIOD_BITS : REG_W;
	// dividend width of the remainder units
	localparam int DIV_W = (STAMP_BITS > PER_W) ? STAMP_BITS : PER_W;
	localparam int CNT_W = $clog2(DIV_W + 1);

	localparam int ADDR_W = 3;

	localparam logic [1:0] DIR_IDLE    = 2'd0;
	localparam logic [1:0] DIR_EXTEND  = 2'd1;
	localparam logic [1:0] DIR_RETRACT = 2'd3;

	localparam logic REG_PERIOD = 1'b0;
	localparam logic REG_WINDOW = 1'b1;

	localparam logic [REG_W-1:0] PERIOD_RESET = REG_W'(1000000);
	localparam logic [REG_W-1:0] WINDOW_RESET = '0;

	typedef struct packed {
		logic [REG_W-1:0] period;
		logic [REG_W-1:0] window;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_COMB,
		ST_FIN
	} state_t;

endpackage

// ----- rtl/srpe_apb_regs.sv -----
// ----------------------------------------------------------------------------
// srpe_apb_regs
// configuration registers behind an apb-style port
// ----------------------------------------------------------------------------
module srpe_apb_regs
	import srpe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output logic [REG_W-1:0]  prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [REG_W-1:0] period_q;
	logic [REG_W-1:0] window_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			window_q <= WINDOW_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_PERIOD: period_q <= pwdata;
				REG_WINDOW: window_q <= pwdata;
				default:    period_q <= period_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PERIOD: prdata = period_q;
			REG_WINDOW: prdata = window_q;
			default:    prdata = '0;
		endcase
	end

	assign cfg.period = period_q;
	assign cfg.window = window_q;

endmodule

// ----- rtl/srpe_mod_unit.sv -----
// ----------------------------------------------------------------------------
// srpe_mod_unit
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
module srpe_mod_unit
	import srpe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [PER_W-1:0] divisor,
	output logic             done,
	output logic [PER_W-1:0] remainder
);

	logic [DIV_W-1:0] dvd_q;
	logic [PER_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PER_W:0]   trial;
	logic [PER_W:0]   diff;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIV_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= diff[PER_W-1:0];
			end else begin
				rem_q <= trial[PER_W-1:0];
			end
		end
	end

	assign done      = (cnt_q == CNT_W'(1));
	assign remainder = rem_q;

endmodule

// ----- rtl/reed_switch_position_emulator_core.sv -----
// ----------------------------------------------------------------------------
// reed_switch_position_emulator_core
// reed switch emulation on a rotating motor from extend/retract commands
//
// input channel: in_valid/in_stall with extend_line, retract_line and
// timestamp_us; output channel: out_valid/out_stall with switch_closed and
// conflict_error, one result per input transfer, in order.
// registers: revolution_period_us at 0x0, trigger_window_us at 0x4.
// an item with a stored command before it and a nonzero period runs two
// bit-serial remainder units in parallel over all DIV_W (48) dividend bits,
// then the remainders are combined (ST_COMB) and the result is registered
// (ST_FIN); a new item is taken only after that result is registered.
// conflicting items, the first command and a zero period skip the
// remainder units and go straight to the final stage (ST_FIN).
// in_stall is high while an item is being worked on. a finished result waits
// in the output register while out_stall is high; the next item may be taken
// meanwhile and holds in its last stage until the output register frees.
// reset loads the register defaults, clears position, timestamp, direction
// and the seen-a-command flag, and empties the output register.
// ----------------------------------------------------------------------------
module reed_switch_position_emulator_core
	import srpe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [REG_W-1:0]      pwdata,
	output logic [REG_W-1:0]      prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  extend_line,
	input  logic                  retract_line,
	input  logic [STAMP_BITS-1:0] timestamp_us,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  switch_closed,
	output logic                  conflict_error
);

	cfg_t                  cfg;
	state_t                state_q;
	state_t                state_d;
	logic                  mod_start;
	logic                  done_a;
	logic                  done_b;

	logic [PER_W-1:0]      pos_q;
	logic [STAMP_BITS-1:0] last_stamp_q;
	logic [1:0]            last_dir_q;
	logic                  have_last_q;
	logic [1:0]            op_dir_q;
	logic                  conflict_q;
	logic                  out_valid_q;
	logic                  switch_closed_q;
	logic                  conflict_error_q;

	logic                  in_acc;
	logic                  conflict;
	logic [1:0]            new_dir;
	logic [PER_W-1:0]      period;
	logic                  period_zero;
	logic [STAMP_BITS-1:0] elapsed;
	logic [PER_W-1:0]      rem_a;
	logic [PER_W-1:0]      rem_b;
	logic [PER_W:0]        sum;
	logic [PER_W:0]        dif;
	logic [PER_W:0]        dif_fix;
	logic [PER_W-1:0]      new_pos;
	logic                  slot_free;
	logic                  fin_load;

	srpe_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign period      = cfg.period[PER_W-1:0];
	assign period_zero = (period == '0);
	assign in_acc      = in_valid && !in_stall;
	assign conflict    = extend_line && retract_line;
	assign new_dir     = extend_line ? DIR_EXTEND : (retract_line ? DIR_RETRACT : DIR_IDLE);
	assign elapsed     = timestamp_us - last_stamp_q;

	assign mod_start = in_acc && !conflict && have_last_q && !period_zero;

	// elapsed time modulo period
	srpe_mod_unit u_mod_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (DIV_W'(elapsed)),
		.divisor   (period),
		.done      (done_a),
		.remainder (rem_a)
	);

	// old position modulo period
	srpe_mod_unit u_mod_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (DIV_W'(pos_q)),
		.divisor   (period),
		.done      (done_b),
		.remainder (rem_b)
	);

	assign sum     = {1'b0, rem_b} + {1'b0, rem_a};
	assign dif     = {1'b0, rem_b} - {1'b0, rem_a};
	assign dif_fix = dif + {1'b0, period};

	always_comb begin
		case (op_dir_q)
			DIR_EXTEND: begin
				if (sum >= {1'b0, period}) begin
					new_pos = PER_W'(sum - {1'b0, period});
				end else begin
					new_pos = sum[PER_W-1:0];
				end
			end
			DIR_RETRACT: begin
				if (dif[PER_W]) begin
					new_pos = dif_fix[PER_W-1:0];
				end else begin
					new_pos = dif[PER_W-1:0];
				end
			end
			default: new_pos = rem_b;
		endcase
	end

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		fin_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = mod_start ? ST_DIV : ST_FIN;
				end
			end
			ST_DIV: begin
				if (done_a) begin
					state_d = ST_COMB;
				end
			end
			ST_COMB: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (slot_free) begin
					fin_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_q        <= '0;
			last_stamp_q <= '0;
			last_dir_q   <= DIR_IDLE;
			have_last_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc && !conflict) begin
				last_stamp_q <= timestamp_us;
				last_dir_q   <= new_dir;
				have_last_q  <= 1'b1;
				if (have_last_q && period_zero) begin
					pos_q <= '0;
				end
			end
			if (state_q == ST_COMB) begin
				pos_q <= new_pos;
			end
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_dir_q   <= last_dir_q;
			conflict_q <= conflict;
		end
		if (fin_load) begin
			switch_closed_q  <= !conflict_q && (REG_W'(pos_q) <= cfg.window);
			conflict_error_q <= conflict_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign switch_closed  = switch_closed_q;
	assign conflict_error = conflict_error_q;

	a_units_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		done_a == done_b)
		else $error("remainder units out of step");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		done_a |-> state_q == ST_DIV)
		else $error("remainder done outside divide state");

	a_conflict_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && conflict |=> $stable(last_stamp_q) && $stable(have_last_q)
			&& $stable(pos_q) && state_q == ST_FIN)
		else $error("conflicting command changed state");

	a_result_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |=> out_valid_q && state_q == ST_IDLE)
		else $error("result not presented after final stage");

endmodule

// ----- dv/reed_switch_position_emulator_core_tb.sv -----
// ----------------------------------------------------------------------------
// reed_switch_position_emulator_core_tb
// self-checking bench for the reed switch position emulator core
//
// a clocked driver feeds command transfers from a queue of pending items and
// a clocked monitor checks every result transfer against a position tracker
// kept inside the bench. the run steps through register settings (period of
// one, zero, the largest, random) and through phases of random sender idling
// and receiver stalling, starting with hand-picked commands.
// ----------------------------------------------------------------------------
module reed_switch_position_emulator_core_tb
	import srpe_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic                  ext;
		logic                  ret;
		logic [STAMP_BITS-1:0] ts;
	} command_t;

	typedef struct {
		logic closed;
		logic conflict;
	} switch_state_t;

	typedef enum int {
		PACE_FREE,
		PACE_SEND,
		PACE_RECV,
		PACE_BOTH
	} pace_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_W-1:0]     paddr = '0;
	logic [REG_W-1:0]      pwdata = '0;
	logic [REG_W-1:0]      prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  extend_line = 1'b0;
	logic                  retract_line = 1'b0;
	logic [STAMP_BITS-1:0] timestamp_us = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  switch_closed;
	logic                  conflict_error;

	command_t      pending_cmds[$];
	switch_state_t expected_switch[$];
	pace_t         pace = PACE_FREE;
	int            errors = 0;

	// bench copy of registers and emulator state
	logic [REG_W-1:0]      period_cfg = PERIOD_RESET;
	logic [REG_W-1:0]      window_cfg = WINDOW_RESET;
	logic [31:0]           pos_trk = '0;
	logic [STAMP_BITS-1:0] stamp_trk = '0;
	logic [1:0]            dir_trk = DIR_IDLE;
	logic                  seen_trk = 1'b0;

	logic [STAMP_BITS-1:0] gen_ts = '0;
	command_t              next_cmd;
	switch_state_t         got_exp;

	reed_switch_position_emulator_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.extend_line    (extend_line),
		.retract_line   (retract_line),
		.timestamp_us   (timestamp_us),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.switch_closed  (switch_closed),
		.conflict_error (conflict_error)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic switch_state_t advance_position(input logic ext, input logic ret,
			input logic [STAMP_BITS-1:0] now);
		switch_state_t         r;
		logic [1:0]            dir;
		logic [STAMP_BITS-1:0] diff;
		logic [63:0]           per;
		logic [63:0]           b;
		logic [63:0]           a;
		if (ext && ret) begin
			r.closed = 1'b0;
			r.conflict = 1'b1;
			return r;
		end
		dir = ext ? DIR_EXTEND : (ret ? DIR_RETRACT : DIR_IDLE);
		if (seen_trk) begin
			per = 64'(period_cfg[PER_W-1:0]);
			diff = now - stamp_trk;
			if (per == 64'd0) begin
				pos_trk = '0;
			end else begin
				b = 64'(pos_trk) % per;
				a = 64'(diff) % per;
				case (dir_trk)
					DIR_EXTEND: begin
						pos_trk = 32'((b + a) % per);
					end
					DIR_RETRACT: begin
						pos_trk = (b >= a) ? 32'(b - a) : 32'(b + per - a);
					end
					default: begin
						pos_trk = 32'(b);
					end
				endcase
			end
		end
		dir_trk = dir;
		stamp_trk = now;
		seen_trk = 1'b1;
		r.closed = (pos_trk <= window_cfg);
		r.conflict = 1'b0;
		return r;
	endfunction

	function automatic bit hold_off(input bit sender);
		case (pace)
			PACE_SEND: return sender && ($urandom_range(0, 99) < 79);
			PACE_RECV: return !sender && ($urandom_range(0, 99) < 79);
			PACE_BOTH: return $urandom_range(0, 99) < 6;
			default:   return 1'b0;
		endcase
	endfunction

	// driver
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_switch.push_back(advance_position(extend_line, retract_line, timestamp_us));
		end
		if (!in_valid || !in_stall) begin
			if (arst_n && pending_cmds.size() > 0 && !hold_off(1'b1)) begin
				next_cmd = pending_cmds.pop_front();
				in_valid <= 1'b1;
				extend_line <= next_cmd.ext;
				retract_line <= next_cmd.ret;
				timestamp_us <= next_cmd.ts;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_switch.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				got_exp = expected_switch.pop_front();
				if (switch_closed !== got_exp.closed) begin
					$error("switch_closed: expected %0d, got %0d", got_exp.closed, switch_closed);
					errors++;
				end
				if (conflict_error !== got_exp.conflict) begin
					$error("conflict_error: expected %0d, got %0d", got_exp.conflict,
						conflict_error);
					errors++;
				end
			end
		end
		out_stall <= arst_n ? hold_off(1'b0) : 1'b0;
	end

	task automatic write_reg(input logic idx, input logic [REG_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_PERIOD) begin
			period_cfg = val;
		end else begin
			window_cfg = val;
		end
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || in_valid || expected_switch.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic setup(input logic [REG_W-1:0] per, input logic [REG_W-1:0] win);
		wait_drained();
		write_reg(REG_PERIOD, per);
		write_reg(REG_WINDOW, win);
	endtask

	task automatic push_cmd(input logic ext, input logic ret, input logic [STAMP_BITS-1:0] ts);
		command_t c;
		c.ext = ext;
		c.ret = ret;
		c.ts = ts;
		pending_cmds.push_back(c);
	endtask

	function automatic logic [STAMP_BITS-1:0] rand_stamp();
		return STAMP_BITS'({$urandom, $urandom});
	endfunction

	// mostly forward steps sized to the period, with conflicts, jumps and rewinds
	task automatic push_random(input int n, input logic [REG_W-1:0] per);
		int                    k;
		int                    d;
		logic                  ext;
		logic                  ret;
		logic [63:0]           span;
		logic [STAMP_BITS-1:0] ts;
		span = (per == '0) ? 64'd4000 : 64'(per) * 64'd4;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			d = $urandom_range(0, 9);
			ext = (d >= 2 && d <= 5);
			ret = (d >= 6);
			if (k < 6) begin
				push_cmd(1'b1, 1'b1, rand_stamp());
			end else begin
				if (k < 10) begin
					ts = rand_stamp();
				end else if (k < 14) begin
					ts = gen_ts - STAMP_BITS'($urandom_range(0, 100000));
				end else if (k < 30) begin
					ts = gen_ts + rand_stamp();
				end else begin
					ts = gen_ts + STAMP_BITS'({$urandom, $urandom} % (span + 64'd1));
				end
				gen_ts = ts;
				push_cmd(ext, ret, ts);
			end
		end
	endtask

	initial begin
		logic [REG_W-1:0] per;
		logic [REG_W-1:0] win;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: conflict first, first command, each direction, rewind, wrap
		push_cmd(1'b1, 1'b1, 48'd5);
		push_cmd(1'b0, 1'b0, 48'd100);
		push_cmd(1'b1, 1'b0, 48'd200);
		push_cmd(1'b0, 1'b1, 48'd700);
		push_cmd(1'b1, 1'b0, 48'd900);
		push_cmd(1'b1, 1'b1, 48'hFFFF_FFFF_FFFF);
		push_cmd(1'b0, 1'b0, 48'd600);
		push_cmd(1'b1, 1'b0, 48'd400);
		push_cmd(1'b0, 1'b1, 48'hFFFF_FFFF_FFFF);
		push_cmd(1'b0, 1'b0, 48'd0);
		push_cmd(1'b1, 1'b0, 48'h8000_0000_0000);

		// period changed while running
		setup(32'd7, 32'd0);
		push_cmd(1'b0, 1'b1, 48'h8000_0000_0003);
		push_cmd(1'b1, 1'b0, 48'h8000_0000_0009);
		push_cmd(1'b0, 1'b0, 48'h8000_0000_000A);
		setup(32'd1, 32'd0);
		push_cmd(1'b1, 1'b0, 48'd77);
		push_cmd(1'b0, 1'b1, 48'd12345);

		// zero period clears the position
		setup(32'd0, 32'hFFFF_FFFF);
		push_cmd(1'b1, 1'b0, 48'd99);
		push_cmd(1'b0, 1'b1, 48'hFFFF_0000_0000);
		setup(32'hFFFF_FFFF, 32'd5000);
		push_cmd(1'b1, 1'b0, 48'hFFFF_FFFF_FFFE);
		push_cmd(1'b0, 1'b1, 48'h0000_0000_1000);
		push_cmd(1'b0, 1'b0, 48'h7FFF_FFFF_FFFF);

		gen_ts = 48'h7FFF_FFFF_FFFF;
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 6)
				0: per = $urandom_range(1, 5000);
				1: per = 32'd1;
				2: per = 32'hFFFF_FFFF;
				3: per = 32'd0;
				4: per = $urandom;
				default: per = $urandom_range(100, 100000);
			endcase
			case ($urandom_range(0, 3))
				0: win = 32'd0;
				1: win = 32'hFFFF_FFFF;
				2: win = (per == '0) ? 32'd0 : $urandom_range(0, per);
				default: win = $urandom;
			endcase
			setup(per, win);
			pace = pace_t'(ph % 4);
			push_random(125, per);
		end

		wait_drained();
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#12_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
